FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the tagged header parser.
// Depends on a clock named clk and an active-low reset named arst_n in the user.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while in reset.
`define CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CHK_SAME(lbl, ante, cons, msg)
`define CHK_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/thpl_pkg.sv
// Package for the tagged header parser and lookup block.
// Holds table sizing, status and phase codes, and the request and result structs.
// No dependencies.
package thpl_pkg;

	localparam int MAX_TAGS = 16;
	localparam int CNT_W    = $clog2(MAX_TAGS + 1);
	localparam int IDX_W    = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;

	localparam logic [15:0] MIN_MSG_BYTES = 16'd12;

	localparam logic OP_PARSE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic KIND_PARSE  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BADARG   = 2'd1;
	localparam logic [1:0] STAT_FORMAT   = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_OFFS = 2'd1;
	localparam logic [1:0] PH_TAGS = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic        first_word;
		logic [31:0] msg_word;
		logic [15:0] msg_bytes;
		logic [31:0] query_tag;
	} req_t;

	typedef struct packed {
		logic        result_kind;
		logic [1:0]  status;
		logic [4:0]  tag_count;
		logic [15:0] field_offset;
		logic [15:0] field_length;
	} res_t;

endpackage

FILE: hdl/tagged_header_parser_lookup.sv
// Tagged header parser and lookup: one request at a time, busy while it works.
// Parse word: accepted, executed in the next cycle (busy in that cycle), result
// strobe (done) in the cycle after that, but only on the last tag word or an error.
// A new word is taken only after the last one executed. Lookup: the table walk uses
// one registered memory read and one tag compare per entry (read, then compare state).
// Results cannot be stalled. arst_n clears the table count and the parser phase.
module tagged_header_parser_lookup (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  thpl_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output thpl_pkg::res_t result
);
	import thpl_pkg::*;

	`include "assert_macros.svh"

	// Sequencer codes
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_PARSE  = 2'd1;
	localparam logic [1:0] S_LK_RD  = 2'd2;
	localparam logic [1:0] S_LK_CMP = 2'd3;

	logic [1:0]       state_q, state_d;
	logic             done_q, done_d;
	res_t             res_q, res_d;
	req_t             req_q;

	// Parser and table bookkeeping
	logic [CNT_W-1:0] valid_q, valid_d;
	logic [CNT_W-1:0] pending_q, pending_d;
	logic [CNT_W-1:0] wi_q, wi_d;
	logic [1:0]       phase_q, phase_d;
	logic [15:0]      saved_q, saved_d;
	logic [15:0]      last_off_q, last_off_d;
	logic [31:0]      prev_tag_q, prev_tag_d;
	logic [CNT_W-1:0] scan_q, scan_d;

	// Table memories: one write port and one registered read port each
	logic [31:0] tag_mem [MAX_TAGS];
	logic [15:0] off_mem [MAX_TAGS];
	logic [15:0] len_mem [MAX_TAGS];
	logic [31:0] tag_rd_q;
	logic [15:0] off_rd_q;
	logic [15:0] len_rd_q;

	logic             tag_we, off_we, len_we;
	logic [IDX_W-1:0] tag_wa, off_wa, len_wa;
	logic [31:0]      tag_wd;
	logic [15:0]      off_wd, len_wd;

	// Parse step outcome
	logic             p_fail;
	logic [1:0]       p_stat;
	logic             p_ok;
	logic             p_upd;

	// Shared arithmetic for the parse step
	logic [CNT_W+2:0] hlen;
	logic [32:0]      off_sum;
	logic [CNT_W-1:0] wi_inc;
	logic [CNT_W-1:0] last_cnt;
	logic [CNT_W:0]   wi_plus2;
	logic             tag_hit;

	assign hlen     = {req_q.msg_word[CNT_W-1:0], 3'b000};
	assign off_sum  = 33'(req_q.msg_word) + 33'({pending_q, 3'b000});
	assign wi_inc   = wi_q + CNT_W'(1);
	assign last_cnt = pending_q - CNT_W'(1);
	assign wi_plus2 = (CNT_W+1)'(wi_q) + (CNT_W+1)'(2);
	assign tag_hit  = (tag_rd_q == req_q.query_tag);

	// One parse word: validate against the running header state and pick
	// the table writes. Applied only in the execute cycle.
	always_comb begin
		wi_d       = wi_q;
		phase_d    = phase_q;
		pending_d  = pending_q;
		valid_d    = valid_q;
		saved_d    = saved_q;
		last_off_d = last_off_q;
		prev_tag_d = prev_tag_q;
		p_fail     = 1'b0;
		p_stat     = STAT_FORMAT;
		p_ok       = 1'b0;
		tag_we     = 1'b0;
		off_we     = 1'b0;
		len_we     = 1'b0;
		tag_wa     = wi_q[IDX_W-1:0];
		off_wa     = '0;
		len_wa     = wi_q[IDX_W-1:0];
		tag_wd     = req_q.msg_word;
		off_wd     = off_sum[15:0];
		len_wd     = off_sum[15:0] - last_off_q;

		if (req_q.first_word) begin
			// New message: drop any running parse and empty the table.
			valid_d = '0;
			saved_d = req_q.msg_bytes;
			if (req_q.msg_bytes < MIN_MSG_BYTES || req_q.msg_bytes[1:0] != 2'b00) begin
				p_fail = 1'b1;
				p_stat = STAT_BADARG;
			end else if (req_q.msg_word == 32'd0 || req_q.msg_word > 32'(MAX_TAGS) ||
			             16'(hlen) > req_q.msg_bytes) begin
				p_fail = 1'b1;
				p_stat = STAT_FORMAT;
			end else begin
				pending_d  = req_q.msg_word[CNT_W-1:0];
				last_off_d = 16'(hlen);
				off_we     = 1'b1;
				off_wa     = '0;
				off_wd     = 16'(hlen);
				wi_d       = '0;
				phase_d    = (req_q.msg_word > 32'd1) ? PH_OFFS : PH_TAGS;
			end
		end else begin
			case (phase_q)
				PH_OFFS: begin
					if (wi_inc >= CNT_W'(MAX_TAGS) || wi_q >= CNT_W'(MAX_TAGS)) begin
						p_fail = 1'b1;
					end else if (req_q.msg_word[1:0] != 2'b00 ||
					             off_sum < 33'(last_off_q) || off_sum > 33'(saved_q)) begin
						p_fail = 1'b1;
					end else begin
						off_we     = 1'b1;
						off_wa     = wi_inc[IDX_W-1:0];
						len_we     = 1'b1;
						len_wa     = wi_q[IDX_W-1:0];
						last_off_d = off_sum[15:0];
						if (wi_plus2 >= {1'b0, pending_q}) begin
							wi_d    = '0;
							phase_d = PH_TAGS;
						end else begin
							wi_d = wi_inc;
						end
					end
				end
				PH_TAGS: begin
					if (wi_q >= CNT_W'(MAX_TAGS)) begin
						p_fail = 1'b1;
					end else if (wi_q != '0 && req_q.msg_word <= prev_tag_q) begin
						p_fail = 1'b1;
					end else begin
						tag_we     = 1'b1;
						prev_tag_d = req_q.msg_word;
						if (wi_inc < pending_q) begin
							wi_d = wi_inc;
						end else if (pending_q == '0) begin
							p_fail = 1'b1;
						end else begin
							// Last tag: close the final field at the message end.
							len_we  = 1'b1;
							len_wa  = last_cnt[IDX_W-1:0];
							len_wd  = saved_q - last_off_q;
							valid_d = pending_q;
							phase_d = PH_IDLE;
							wi_d    = '0;
							p_ok    = 1'b1;
						end
					end
				end
				default: begin
					// Stray word while idle: drop it.
				end
			endcase
		end

		if (p_fail) begin
			valid_d = '0;
			phase_d = PH_IDLE;
			wi_d    = '0;
		end
	end

	// Sequencer: accept, execute a parse step, or walk the table.
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		res_d   = res_q;
		scan_d  = scan_q;
		p_upd   = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					scan_d  = '0;
					state_d = (req.opcode == OP_LOOKUP) ? S_LK_RD : S_PARSE;
				end
			end
			S_PARSE: begin
				p_upd   = 1'b1;
				state_d = S_IDLE;
				if (p_fail || p_ok) begin
					done_d             = 1'b1;
					res_d.result_kind  = KIND_PARSE;
					res_d.status       = p_ok ? STAT_OK : p_stat;
					res_d.tag_count    = p_ok ? 5'(pending_q) : 5'd0;
					res_d.field_offset = 16'd0;
					res_d.field_length = 16'd0;
				end
			end
			S_LK_RD: begin
				// Read of entry scan_q lands in the read registers at this edge.
				if (scan_q >= valid_q) begin
					done_d             = 1'b1;
					res_d.result_kind  = KIND_LOOKUP;
					res_d.status       = STAT_NOTFOUND;
					res_d.tag_count    = 5'd0;
					res_d.field_offset = 16'd0;
					res_d.field_length = 16'd0;
					state_d            = S_IDLE;
				end else begin
					state_d = S_LK_CMP;
				end
			end
			S_LK_CMP: begin
				if (tag_hit) begin
					done_d             = 1'b1;
					res_d.result_kind  = KIND_LOOKUP;
					res_d.status       = STAT_OK;
					res_d.tag_count    = 5'd0;
					res_d.field_offset = off_rd_q;
					res_d.field_length = len_rd_q;
					state_d            = S_IDLE;
				end else begin
					scan_d  = scan_q + CNT_W'(1);
					state_d = S_LK_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			valid_q   <= '0;
			pending_q <= '0;
			wi_q      <= '0;
			phase_q   <= PH_IDLE;
			saved_q   <= '0;
			scan_q    <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			scan_q  <= scan_d;
			if (p_upd) begin
				valid_q   <= valid_d;
				pending_q <= pending_d;
				wi_q      <= wi_d;
				phase_q   <= phase_d;
				saved_q   <= saved_d;
			end
		end
	end

	// Payload registers: hold the request, the result and the parse history.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		res_q <= res_d;
		if (p_upd) begin
			last_off_q <= last_off_d;
			prev_tag_q <= prev_tag_d;
		end
	end

	// Table memories
	always_ff @(posedge clk) begin
		if (p_upd && tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		if (p_upd && off_we) begin
			off_mem[off_wa] <= off_wd;
		end
		if (p_upd && len_we) begin
			len_mem[len_wa] <= len_wd;
		end
		tag_rd_q <= tag_mem[scan_q[IDX_W-1:0]];
		off_rd_q <= off_mem[scan_q[IDX_W-1:0]];
		len_rd_q <= len_mem[scan_q[IDX_W-1:0]];
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// A result only appears once the sequencer is back at rest.
	`CHK_SAME(a_done_idle, done_q, !busy, "result strobe while busy")
	// Every accepted request makes the block busy in the next cycle.
	`CHK_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not go busy")
	// A successful parse always reports a nonzero tag count.
	`CHK_SAME(a_ok_count, done_q && res_q.result_kind == KIND_PARSE &&
		res_q.status == STAT_OK, res_q.tag_count != 5'd0, "parse ok with zero tags")
	// The recorded tag count never exceeds the table size.
	`CHK_SAME(a_valid_max, 1'b1, valid_q <= CNT_W'(MAX_TAGS), "table count overflow")

endmodule
